FILE: sv/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned CODE_W    = 16;
   localparam int unsigned SKIP_W    = 2;
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_AW   = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CW   = $clog2(FIFO_DEPTH + 1);

   localparam logic [CODE_W-1:0] REPLACEMENT_CHAR = 16'hFFFD;
   localparam logic [SKIP_W-1:0] SKIP_AFTER_LEAD4 = 2'd3;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_TWO_1   = 3'd1,
      MODE_THREE_2 = 3'd2,
      MODE_THREE_1 = 3'd3,
      MODE_SKIP    = 3'd4
   } mode_type;

   typedef struct packed {
      mode_type              mode;
      logic [CODE_W-1:0]     partial_code;
      logic [SKIP_W-1:0]     skip_left;
   } dec_state_type;

   typedef struct packed {
      logic [CODE_W-1:0] code_point;
      logic              end_of_text;
      logic              last_of_run;
   } result_type;

endpackage

FILE: sv/u8sd_decode.sv
// ----------------------------------------------------------------------------
// u8sd_decode
// Decodes one text byte against the current state: next state and up to
// two results.
// ----------------------------------------------------------------------------
module u8sd_decode
   import u8sd_pkg::*;
(
   input  logic [BYTE_W-1:0] text_byte,
   input  dec_state_type     cur_state,
   output dec_state_type     nxt_state,
   output logic [1:0]        res_count,
   output result_type        res0,
   output result_type        res1
);

   logic       pending;
   logic       is_cont;
   result_type eot_res;

   assign pending = (cur_state.mode == MODE_TWO_1) || (cur_state.mode == MODE_THREE_2) ||
                    (cur_state.mode == MODE_THREE_1);
   assign is_cont = (text_byte[7:6] == 2'b10);

   always_comb begin
      eot_res = '{code_point: '0, end_of_text: 1'b1, last_of_run: 1'b1};
   end

   always_comb begin
      logic do_lead;
      do_lead   = 1'b0;
      nxt_state = cur_state;
      res_count = 2'd0;
      res0      = '{code_point: '0, end_of_text: 1'b0, last_of_run: 1'b1};
      res1      = eot_res;

      if (text_byte == '0) begin
         // end of text: flush any partial code point, then the terminator
         nxt_state = '{mode: MODE_IDLE, partial_code: '0, skip_left: '0};
         if (pending) begin
            res0      = '{code_point: cur_state.partial_code, end_of_text: 1'b0,
                          last_of_run: 1'b0};
            res_count = 2'd2;
         end else begin
            res0      = eot_res;
            res_count = 2'd1;
         end
      end else begin
         unique case (cur_state.mode)
            MODE_TWO_1, MODE_THREE_1: begin
               res0.code_point        = cur_state.partial_code |
                                        {10'd0, text_byte[5:0]};
               res_count              = 2'd1;
               nxt_state.mode         = MODE_IDLE;
               nxt_state.partial_code = '0;
            end
            MODE_THREE_2: begin
               nxt_state.partial_code = cur_state.partial_code |
                                        {4'd0, text_byte[5:0], 6'd0};
               nxt_state.mode         = MODE_THREE_1;
            end
            MODE_SKIP: begin
               if (is_cont && (cur_state.skip_left != '0)) begin
                  nxt_state.skip_left = cur_state.skip_left - 1'b1;
                  if (cur_state.skip_left == 2'd1) begin
                     nxt_state.mode = MODE_IDLE;
                  end
               end else begin
                  do_lead = 1'b1;
               end
            end
            default: begin
               do_lead = 1'b1;
            end
         endcase

         if (do_lead) begin
            nxt_state.mode      = MODE_IDLE;
            nxt_state.skip_left = '0;
            priority if (text_byte[7] == 1'b0) begin
               res0.code_point = {8'd0, text_byte};
               res_count       = 2'd1;
            end else if (text_byte[7:5] == 3'b110) begin
               nxt_state.partial_code = {5'd0, text_byte[4:0], 6'd0};
               nxt_state.mode         = MODE_TWO_1;
            end else if (text_byte[7:4] == 4'b1110) begin
               nxt_state.partial_code = {text_byte[3:0], 12'd0};
               nxt_state.mode         = MODE_THREE_2;
            end else if (text_byte[7:3] == 5'b11110) begin
               nxt_state.mode      = MODE_SKIP;
               nxt_state.skip_left = SKIP_AFTER_LEAD4;
               res0.code_point     = REPLACEMENT_CHAR;
               res_count           = 2'd1;
            end else begin
               res0.code_point = REPLACEMENT_CHAR;
               res_count       = 2'd1;
            end
         end
      end
   end

endmodule

FILE: sv/u8sd_result_fifo.sv
// ----------------------------------------------------------------------------
// u8sd_result_fifo
// Small result queue: takes up to two results per cycle, hands out one unless stalled.
// ----------------------------------------------------------------------------
module u8sd_result_fifo
   import u8sd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  push_count,
   input  result_type  push0,
   input  result_type  push1,
   output logic        has_room,
   output logic        out_valid,
   input  logic        out_stall,
   output result_type  out_data
);

   result_type           mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]   count_ff, count_in;
   logic                 pop;
   logic [FIFO_AW-1:0]   wr_ptr_nx1;

   assign out_valid  = (count_ff != '0);
   assign out_data   = mem_ff[rd_ptr_ff];
   assign pop        = out_valid && !out_stall;
   // room for a full two-result transaction
   assign has_room   = (count_ff <= FIFO_CW'(FIFO_DEPTH - 2));
   assign wr_ptr_nx1 = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_AW'(push_count);
      rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
      count_in  = count_ff + FIFO_CW'(push_count) - FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_nx1] <= push1;
      end
   end

endmodule

FILE: sv/utf8_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// Byte-serial UTF-8 decoder for the Basic Multilingual Plane: one text byte
// per transaction in, 16-bit code points out.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_text_byte[7:0]
//   rsp      out        rsp_valid/rsp_stall  rsp_code_point[15:0],
//                                            rsp_end_of_text, rsp_last_of_run
//
// One byte is accepted per cycle while req_stall is low; its results are
// written into a four-entry result queue at the same edge and go out on rsp
// in order. A zero byte that closes a pending sequence yields two results, so
// it takes two rsp transactions; the queue absorbs them while input flows.
// req_stall comes from the registered queue fill only (high when fewer than
// two slots are free), never combinationally from rsp_stall.
// Synchronous reset clears the decode state and empties the queue.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core
   import u8sd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [BYTE_W-1:0]   req_text_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CODE_W-1:0]   rsp_code_point,
   output logic                rsp_end_of_text,
   output logic                rsp_last_of_run
);

   dec_state_type state_ff;
   dec_state_type state_in;
   dec_state_type dec_next;
   logic [1:0]    dec_count;
   result_type    dec_res0;
   result_type    dec_res1;
   logic [1:0]    push_count;
   logic          has_room;
   logic          accept;
   result_type    out_data;

   // decode the incoming byte against the held state
   u8sd_decode u_decode (
      .text_byte (req_text_byte),
      .cur_state (state_ff),
      .nxt_state (dec_next),
      .res_count (dec_count),
      .res0      (dec_res0),
      .res1      (dec_res1)
   );

   // accept only when a two-result transaction is guaranteed to fit
   assign req_stall  = !has_room;
   assign accept     = req_valid && has_room;
   assign push_count = accept ? dec_count : 2'd0;

   // advance the state only on an accepted byte, hold otherwise
   always_comb begin
      state_in = accept ? dec_next : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{mode: MODE_IDLE, partial_code: '0, skip_left: '0};
      end else begin
         state_ff <= state_in;
      end
   end

   u8sd_result_fifo u_result_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (dec_res0),
      .push1      (dec_res1),
      .has_room   (has_room),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_data   (out_data)
   );

   assign rsp_code_point  = out_data.code_point;
   assign rsp_end_of_text = out_data.end_of_text;
   assign rsp_last_of_run = out_data.last_of_run;

endmodule

FILE: dv/tb_utf8_stream_decoder_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder_core
// Self-checking bench for the UTF-8 stream decoder. It drives text bytes over
// the req channel and mirrors the decode in a local predictor. Every rsp
// transaction is compared in order against the predicted code points. The run
// covers directed corner cases, a long output hold, and random text under four
// idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder_core;
   import u8sd_pkg::*;

   // -------------------------------------------------------------------------
   // Clock, reset and DUT ports. Give every input a known value from time zero.
   // -------------------------------------------------------------------------
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_text_byte = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [CODE_W-1:0]   rsp_code_point;
   logic                rsp_end_of_text;
   logic                rsp_last_of_run;

   utf8_stream_decoder_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_byte   (req_text_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_end_of_text (rsp_end_of_text),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Bench knobs and bookkeeping
   // -------------------------------------------------------------------------
   int send_idle_pct = 0;   // chance that the sender idles before a byte
   int rsp_stall_pct = 0;   // chance that the receiver stalls a given cycle
   int hold_request  = 0;   // long receiver hold, handed to the stall process
   int hold_left     = 0;

   int err_count       = 0;
   int bytes_sent      = 0;
   int results_checked = 0;
   int eot_seen        = 0;
   int repl_seen       = 0;

   // Predicted rsp transactions, oldest first.
   result_type code_points_due[$];

   // -------------------------------------------------------------------------
   // Decoder predictor: its own copy of the decode state.
   // -------------------------------------------------------------------------
   mode_type            dec_mode    = MODE_IDLE;
   logic [CODE_W-1:0]   dec_partial = '0;
   logic [SKIP_W-1:0]   dec_skip    = '0;

   task automatic push_code(input logic [CODE_W-1:0] cp, input logic eot,
                            input logic last);
      result_type r;
      r.code_point  = cp;
      r.end_of_text = eot;
      r.last_of_run = last;
      code_points_due.push_back(r);
   endtask

   // Decode a nonzero byte as the start of a new character.
   task automatic decode_lead(input logic [BYTE_W-1:0] b);
      dec_mode = MODE_IDLE;
      dec_skip = '0;
      if (b[7] == 1'b0) begin
         push_code({8'd0, b}, 1'b0, 1'b1);
      end else if (b[7:5] == 3'b110) begin
         dec_partial = {5'd0, b[4:0], 6'd0};
         dec_mode    = MODE_TWO_1;
      end else if (b[7:4] == 4'b1110) begin
         dec_partial = {b[3:0], 12'd0};
         dec_mode    = MODE_THREE_2;
      end else if (b[7:3] == 5'b11110) begin
         // Four-byte lead: flag it now, then swallow its continuations.
         dec_mode = MODE_SKIP;
         dec_skip = SKIP_AFTER_LEAD4;
         push_code(REPLACEMENT_CHAR, 1'b0, 1'b1);
      end else begin
         push_code(REPLACEMENT_CHAR, 1'b0, 1'b1);
      end
   endtask

   // Advance the predictor by one accepted byte.
   task automatic decode_byte(input logic [BYTE_W-1:0] b);
      if (b == '0) begin
         // End of text: flush a pending partial code point first.
         if (dec_mode == MODE_TWO_1 || dec_mode == MODE_THREE_2 ||
             dec_mode == MODE_THREE_1)
            push_code(dec_partial, 1'b0, 1'b0);
         push_code('0, 1'b1, 1'b1);
         dec_mode    = MODE_IDLE;
         dec_partial = '0;
         dec_skip    = '0;
      end else begin
         case (dec_mode)
            MODE_TWO_1, MODE_THREE_1: begin
               push_code(dec_partial | {10'd0, b[5:0]}, 1'b0, 1'b1);
               dec_mode    = MODE_IDLE;
               dec_partial = '0;
            end
            MODE_THREE_2: begin
               dec_partial = dec_partial | {4'd0, b[5:0], 6'd0};
               dec_mode    = MODE_THREE_1;
            end
            MODE_SKIP: begin
               if (b[7:6] == 2'b10 && dec_skip != '0) begin
                  dec_skip = dec_skip - 1'b1;
                  if (dec_skip == '0)
                     dec_mode = MODE_IDLE;
               end else begin
                  decode_lead(b);
               end
            end
            default: decode_lead(b);
         endcase
      end
   endtask

   // -------------------------------------------------------------------------
   // Sender: one req transaction. Drive at the falling edge and hold the byte
   // until an edge sees valid without stall. Leave valid high on return so
   // that back-to-back bytes need no extra assignment in the same step.
   // -------------------------------------------------------------------------
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_text_byte <= b;
      do
         @(posedge clock);
      while (req_stall);
      bytes_sent++;
      decode_byte(b);
   endtask

   // Hold off the sender until every predicted result has come out. Drop
   // valid first so the last byte is not taken again while waiting.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (code_points_due.size() != 0)
         @(posedge clock);
   endtask

   // Follow byte for a 2- or 3-byte sequence: mostly a proper continuation,
   // sometimes any nonzero byte, since the block does not check follow bytes.
   function automatic logic [BYTE_W-1:0] follow_byte();
      if ($urandom_range(0, 99) < 85)
         return {2'b10, 6'($urandom_range(0, 63))};
      return 8'($urandom_range(1, 255));
   endfunction

   // Random text, mostly well-formed characters with random payload bits,
   // mixed with stray bytes, cut-off sequences and end-of-text bytes.
   task automatic send_random_text(input int n_bytes);
      int sent;
      int pick;
      int n_cont;
      int k;
      sent = 0;
      while (sent < n_bytes) begin
         pick = $urandom_range(0, 99);
         if (pick < 28) begin
            send_byte(8'($urandom_range(1, 127)));
            sent += 1;
         end else if (pick < 46) begin
            send_byte(8'hC0 | 8'($urandom_range(0, 31)));
            send_byte(follow_byte());
            sent += 2;
         end else if (pick < 64) begin
            send_byte(8'hE0 | 8'($urandom_range(0, 15)));
            send_byte(follow_byte());
            send_byte(follow_byte());
            sent += 3;
         end else if (pick < 76) begin
            // Four-byte lead with anywhere from no continuation to one too many.
            n_cont = $urandom_range(0, 4);
            send_byte(8'hF0 | 8'($urandom_range(0, 7)));
            for (k = 0; k < n_cont; k++)
               send_byte(8'h80 | 8'($urandom_range(0, 63)));
            sent += 1 + n_cont;
         end else if (pick < 84) begin
            // Stray continuation or a lead that no UTF-8 form uses.
            if ($urandom_range(0, 1))
               send_byte(8'($urandom_range(8'h80, 8'hBF)));
            else
               send_byte(8'($urandom_range(8'hF8, 8'hFF)));
            sent += 1;
         end else if (pick < 92) begin
            // Sequence cut off by end of text.
            if ($urandom_range(0, 1))
               send_byte(8'hC0 | 8'($urandom_range(0, 31)));
            else
               send_byte(8'hE0 | 8'($urandom_range(0, 15)));
            sent += 1;
            if ($urandom_range(0, 1)) begin
               send_byte(follow_byte());
               sent += 1;
            end
            send_byte(8'h00);
            sent += 1;
         end else begin
            send_byte(8'h00);
            sent += 1;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Receiver: drive rsp_stall at the falling edge. A long hold requested by a
   // test is counted down here, cycle by cycle, while the sender keeps going.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Result checker: compare each accepted rsp transaction with the oldest
   // prediction, field by field.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (code_points_due.size() == 0) begin
            $error("rsp transaction with nothing predicted: code_point %h", rsp_code_point);
            err_count++;
         end else begin
            want = code_points_due.pop_front();
            results_checked++;
            if (want.end_of_text)
               eot_seen++;
            if (want.code_point == REPLACEMENT_CHAR)
               repl_seen++;
            if (rsp_code_point !== want.code_point) begin
               $error("code_point: expected %h, actual %h", want.code_point, rsp_code_point);
               err_count++;
            end
            if (rsp_end_of_text !== want.end_of_text) begin
               $error("end_of_text: expected %b, actual %b",
                      want.end_of_text, rsp_end_of_text);
               err_count++;
            end
            if (rsp_last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %b, actual %b",
                      want.last_of_run, rsp_last_of_run);
               err_count++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Plain ASCII at both ends of the range, then end of text while idle.
   task automatic test_ascii();
      send_byte(8'h01);
      send_byte(8'h7F);
      send_byte(8'h00);
   endtask

   // Two- and three-byte characters, including the largest two-byte value.
   task automatic test_multi_byte();
      send_byte(8'hC3);
      send_byte(8'hA9);
      send_byte(8'hE2);
      send_byte(8'h82);
      send_byte(8'hAC);
      send_byte(8'hDF);
      send_byte(8'hFF);
   endtask

   // Four-byte lead: swallow three continuations, then decode a fourth as a
   // stray byte; next, cut the skip short with a plain byte.
   task automatic test_four_byte();
      send_byte(8'hF0);
      send_byte(8'h9F);
      send_byte(8'h98);
      send_byte(8'h80);
      send_byte(8'h80);
      send_byte(8'hF4);
      send_byte(8'h90);
      send_byte(8'h41);
   endtask

   // End of text with a two-byte lead pending, with one byte of a three-byte
   // sequence still due, and while skipping continuations.
   task automatic test_end_of_text();
      send_byte(8'hC3);
      send_byte(8'h00);
      send_byte(8'hE2);
      send_byte(8'h82);
      send_byte(8'h00);
      send_byte(8'hF0);
      send_byte(8'h00);
   endtask

   // Leads outside every UTF-8 form.
   task automatic test_invalid_lead();
      send_byte(8'hF8);
      send_byte(8'hFF);
   endtask

   // Hold the receiver for a long stretch while the sender keeps offering
   // bytes, so the result queue fills and req_stall rises; then drain fully.
   task automatic test_backpressure();
      wait_drained();
      hold_request = 80;
      send_random_text(40);
      wait_drained();
   endtask

   // Random text under each idle/stall mix, draining between mixes.
   task automatic test_random_mixes();
      int idle_mix[4]  = '{0, 50, 0, 23};
      int stall_mix[4] = '{0, 0, 50, 23};
      int m;
      for (m = 0; m < 4; m++) begin
         send_idle_pct = idle_mix[m];
         rsp_stall_pct = stall_mix[m];
         send_random_text(180);
         wait_drained();
      end
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_ascii();
      test_multi_byte();
      test_four_byte();
      test_end_of_text();
      test_invalid_lead();
      test_backpressure();
      test_random_mixes();

      // Drop valid after the last transaction, then let the block settle.
      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      repeat (8) @(posedge clock);

      $display("Covered %0d text bytes and %0d checked code points", bytes_sent,
               results_checked);
      $display("(%0d end-of-text, %0d replacement) across directed cases,",
               eot_seen, repl_seen);
      $display("a long output hold and four idle/stall mixes.");
      if (err_count == 0)
         $display("tb_utf8_stream_decoder_core: done, clean");
      else
         $display("tb_utf8_stream_decoder_core: done, errors");
      $finish;
   end

   // Watchdog: a correct run needs only a small fraction of this time.
   initial begin
      #2000000;
      $display("tb_utf8_stream_decoder_core: done, errors");
      $finish;
   end

endmodule

FILE: utf8_stream_decoder_core.f
sv/u8sd_pkg.sv
sv/u8sd_decode.sv
sv/u8sd_result_fifo.sv
sv/utf8_stream_decoder_core.sv
dv/tb_utf8_stream_decoder_core.sv
